FILE: rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants of the stack machine executor
// opcodes, decoded instruction format, transfer payloads and sizing
// ----------------------------------------------------------------------------
package smx_pkg;

  // sizing
  localparam int STACK_DEPTH = 1024;
  localparam int LOCAL_COUNT = 512;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int LOC_AW      = $clog2(LOCAL_COUNT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;

  // program counter advance: opcode byte alone, or opcode byte plus word
  localparam logic [31:0] PC_STEP_OP  = 32'd1;
  localparam logic [31:0] PC_STEP_IMM = 32'd5;

  // opcode bytes
  localparam logic [7:0] ACT_HALT   = 8'h01;
  localparam logic [7:0] ACT_CONST  = 8'h10;
  localparam logic [7:0] ACT_STRING = 8'h12;
  localparam logic [7:0] ACT_ADD    = 8'h20;
  localparam logic [7:0] ACT_SUB    = 8'h21;
  localparam logic [7:0] ACT_MUL    = 8'h22;
  localparam logic [7:0] ACT_LOAD   = 8'h60;
  localparam logic [7:0] ACT_STORE  = 8'h61;
  localparam logic [7:0] ACT_CALL   = 8'hF1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE = 1'd1;

  typedef enum logic [3:0] {
    OP_HALT,
    OP_CONST,
    OP_STRING,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_LOAD,
    OP_STORE,
    OP_CALL,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_ISSUE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    logic [7:0]  action;
    logic [31:0] operand;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      top_value;
    logic [CNT_W-1:0] stack_depth;
    logic             is_running;
    logic [31:0]      program_counter;
  } res_t;

  // decoded instruction as held in the queue
  typedef struct packed {
    op_t         op;
    logic        has_imm;
    logic        idx_ok;
    logic [31:0] operand;
  } instr_t;

endpackage

FILE: rtl/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram: generic single write, single read memory
// one write port, one read port with registered read data held when idle
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/smx_front.sv
// ----------------------------------------------------------------------------
// smx_front: instruction intake and decode
// takes command transfers, classifies the opcode and writes the queue
// ----------------------------------------------------------------------------
module smx_front (
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  smx_pkg::cmd_t   cmd,
  input  logic            clearing,
  input  logic            q_full,
  output logic            q_push,
  output smx_pkg::instr_t q_data
);
  import smx_pkg::*;

  op_t  op;
  logic has_imm;

  always_comb begin
    has_imm = 1'b0;
    unique case (cmd.action)
      ACT_HALT:   op = OP_HALT;
      ACT_CONST:  begin op = OP_CONST;  has_imm = 1'b1; end
      ACT_STRING: begin op = OP_STRING; has_imm = 1'b1; end
      ACT_ADD:    op = OP_ADD;
      ACT_SUB:    op = OP_SUB;
      ACT_MUL:    op = OP_MUL;
      ACT_LOAD:   begin op = OP_LOAD;   has_imm = 1'b1; end
      ACT_STORE:  begin op = OP_STORE;  has_imm = 1'b1; end
      ACT_CALL:   op = OP_CALL;
      default:    op = OP_BAD;
    endcase
  end

  assign cmd_stall       = clearing | q_full;
  assign q_push          = cmd_valid & ~cmd_stall;
  assign q_data.op       = op;
  assign q_data.has_imm  = has_imm;
  assign q_data.idx_ok   = (cmd.operand < 32'(LOCAL_COUNT));
  assign q_data.operand  = cmd.operand;

endmodule

FILE: rtl/smx_queue.sv
// ----------------------------------------------------------------------------
// smx_queue: short instruction queue between decode and execute
// first in first out, head shown combinationally
// ----------------------------------------------------------------------------
module smx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smx_pkg::instr_t data_in,
  output logic            full,
  output logic            avail,
  output smx_pkg::instr_t head,
  input  logic            pop
);
  import smx_pkg::*;

  instr_t               entry [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QCNT_W-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= data_in;
    end
  end

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = entry[rd_ptr];

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");
`endif

endmodule

FILE: rtl/smx_back.sv
// ----------------------------------------------------------------------------
// smx_back: execute stage of the stack machine
// owns stack, locals, pc, run flag and configuration; issues memory reads,
// then applies one instruction and registers its result
// ----------------------------------------------------------------------------
module smx_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [smx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           q_avail,
  input  smx_pkg::instr_t                q_head,
  output logic                           q_pop,
  output logic                           clearing,
  output logic                           res_valid,
  input  logic                           res_stall,
  output smx_pkg::res_t                  res
);
  import smx_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  logic             commit;

  logic [31:0]      prog_len;
  logic [31:0]      code_base;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      top;
  logic [31:0]      top_next;
  logic [31:0]      pc;
  logic [31:0]      pc_next;
  logic             run;
  logic             run_next;

  instr_t           cur;
  logic             go;
  logic [31:0]      pc_adv;
  logic [LOC_AW-1:0] clr_idx;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic             has1;
  logic             has2;
  logic             stk_full;
  logic [31:0]      opa;
  logic [31:0]      opb;
  logic [31:0]      alu;
  logic             push_en;
  logic [31:0]      push_val;
  logic             stk_push;
  logic             loc_wr;

  logic              stk_we;
  logic              stk_re;
  logic [STK_AW-1:0] stk_raddr;
  logic [31:0]       stk_rdata;
  logic              loc_we;
  logic [LOC_AW-1:0] loc_waddr;
  logic [31:0]       loc_wdata;
  logic              loc_re;
  logic [31:0]       loc_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len  <= '0;
      code_base <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PROG_LEN:  prog_len  <= cfg_data;
        CFG_CODE_BASE: code_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        if (clr_idx == LOC_AW'(LOCAL_COUNT - 1)) begin
          state_next = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        if (q_avail) begin
          q_pop      = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!res_valid || !res_stall) begin
          commit     = 1'b1;
          state_next = BK_ISSUE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  assign clearing = (state == BK_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // issue: latch instruction, precompute pc and stop test
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur    <= q_head;
      go     <= run && (pc < prog_len);
      pc_adv <= pc + (q_head.has_imm ? PC_STEP_IMM : PC_STEP_OP);
    end
  end

  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign has1      = (count != '0);
  assign has2      = (count > CNT_W'(1));
  assign stk_full  = (count == CNT_W'(STACK_DEPTH));

  assign stk_re    = q_pop && has2;
  assign stk_raddr = cnt_m2[STK_AW-1:0];
  assign loc_re    = q_pop && (q_head.op == OP_LOAD) && q_head.idx_ok;

  // execute
  assign opa = has2 ? stk_rdata : '0;
  assign opb = has1 ? top : '0;

  always_comb begin
    case (cur.op)
      OP_SUB:  alu = opa - opb;
      OP_MUL:  alu = opa * opb;
      default: alu = opa + opb;
    endcase
  end

  always_comb begin
    count_next = count;
    top_next   = top;
    pc_next    = pc;
    run_next   = run;
    push_en    = 1'b0;
    push_val   = cur.operand;
    stk_push   = 1'b0;
    loc_wr     = 1'b0;
    if (!go) begin
      run_next = 1'b0;
    end else begin
      pc_next = pc_adv;
      case (cur.op) inside
        OP_CONST: begin
          push_en = 1'b1;
        end
        OP_STRING: begin
          push_en  = 1'b1;
          push_val = code_base + pc_adv;
          pc_next  = pc_adv + cur.operand;
        end
        OP_LOAD: begin
          push_en  = cur.idx_ok;
          push_val = loc_rdata;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          count_next = has2 ? cnt_m1 : CNT_W'(1);
          top_next   = alu;
        end
        OP_STORE: begin
          if (cur.idx_ok) begin
            loc_wr     = 1'b1;
            count_next = has1 ? cnt_m1 : '0;
            top_next   = stk_rdata;
          end
        end
        OP_CALL: begin
          count_next = has2 ? cnt_m1 : CNT_W'(1);
          top_next   = '0;
        end
        default: begin
          run_next = 1'b0;
        end
      endcase
      // the old top moves down into the stack memory
      if (push_en && !stk_full) begin
        stk_push   = has1;
        top_next   = push_val;
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pc    <= '0;
      run   <= 1'b1;
    end else if (commit) begin
      count <= count_next;
      pc    <= pc_next;
      run   <= run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      top <= top_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.top_value       <= (count_next != '0) ? top_next : '0;
      res.stack_depth     <= count_next;
      res.is_running      <= run_next;
      res.program_counter <= pc_next;
    end
  end

  // memories
  assign stk_we    = commit && stk_push;
  assign loc_we    = clearing || (commit && loc_wr);
  assign loc_waddr = clearing ? clr_idx : cur.operand[LOC_AW-1:0];
  assign loc_wdata = clearing ? '0 : opb;

  smx_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt_m1[STK_AW-1:0]),
    .wdata (top),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  smx_ram #(
    .WIDTH (32),
    .DEPTH (LOCAL_COUNT)
  ) u_local_ram (
    .clk   (clk),
    .we    (loc_we),
    .waddr (loc_waddr),
    .wdata (loc_wdata),
    .re    (loc_re),
    .raddr (q_head.operand[LOC_AW-1:0]),
    .rdata (loc_rdata)
  );

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_when_issuing: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_ISSUE) && q_avail)
    else $error("queue popped outside issue");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == BK_EXEC))
    else $error("result raised without execute");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    !run |=> !run)
    else $error("run flag set again after stop");

  a_stack_write_range: assert property (@(posedge clk) disable iff (rst)
    stk_we |-> has1 && !stk_full)
    else $error("stack spill outside live range");
`endif

endmodule

FILE: rtl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor: decoded stack machine instruction executor
// runs one instruction per command transfer and returns the machine state
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// cmd       in         cmd_valid/cmd_stall  action, operand
// res       out        res_valid/res_stall  top_value, stack_depth,
//                                           is_running, program_counter
// cfg       in         cfg_write            cfg_index, cfg_data
//
// each instruction passes through the issue state, which issues the stack and
// local memory reads, then the execute state, which applies the result; the
// registered read of the memories sets this, so execute takes no new instruction
// until the last is applied; after reset the 512 locals are zeroed one per
// cycle, with cmd_stall held high; configuration writes are taken throughout
// a stalled result holds execute, while decode keeps filling a two-deep queue
//
module stack_machine_executor (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [smx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  // instruction transfers
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  smx_pkg::cmd_t                 cmd,
  // result transfers
  output logic                          res_valid,
  input  logic                          res_stall,
  output smx_pkg::res_t                 res
);
  import smx_pkg::*;

  // decode to queue
  logic   q_push;
  instr_t q_data;
  logic   q_full;
  // queue to execute
  logic   q_avail;
  instr_t q_head;
  logic   q_pop;
  // local store sweep in progress, blocks intake
  logic   clearing;

  smx_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  smx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .data_in (q_data),
    .full    (q_full),
    .avail   (q_avail),
    .head    (q_head),
    .pop     (q_pop)
  );

  // execute owns all machine state and the result register
  smx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

FILE: dv/stack_machine_executor_tb.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_tb: self-checking bench for the stack machine executor
// a directed table then random instruction streams are driven over the
// command channel; every result transfer is checked field by field against
// an in-bench model of the machine state, with random stalls on both sides
// ----------------------------------------------------------------------------
module stack_machine_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smx_pkg::*;

  // opcode that the block deliberately treats as unknown
  localparam logic [7:0] ACT_LIBC_FWD = 8'hF0;
  localparam int CYCLE_LIMIT = 600000;
  // the machine must stay well below the program length while random streams run
  localparam logic [31:0] PC_MARGIN = 32'h0001_0000;
  localparam int LONG_HOLD = 400;

  typedef enum int {
    END_BY_HALT,
    END_BY_UNKNOWN,
    END_BY_SIZE
  } stop_kind_t;

  typedef struct {
    cmd_t instr;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 cmd_valid;
  logic                 cmd_stall;
  cmd_t                 cmd;
  logic                 res_valid;
  logic                 res_stall;
  res_t                 res;

  // machine state as predicted from accepted instructions
  logic [31:0]  model_stack [STACK_DEPTH];
  int unsigned  model_depth;
  logic [31:0]  model_locals [LOCAL_COUNT];
  logic [31:0]  model_pc;
  logic         model_running;
  logic [31:0]  model_prog_len;
  logic [31:0]  model_code_base;

  res_t         pending_states [$];
  dir_row_t     dir_rows [$];
  int           error_count = 0;
  int unsigned  cycle_count = 0;
  bit           hold_request = 1'b0;

  stack_machine_executor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop in case a transfer never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // machine model
  // ---------------------------------------------------------------------------

  // a push onto a full stack is silently dropped
  function automatic void stack_push(logic [31:0] v);
    if (model_depth < STACK_DEPTH) begin
      model_stack[model_depth] = v;
      model_depth++;
    end
  endfunction

  // popping an empty stack gives zero and leaves the depth at zero
  function automatic logic [31:0] stack_pop();
    if (model_depth == 0) return 32'd0;
    model_depth--;
    return model_stack[model_depth];
  endfunction

  // executes one instruction on the model and returns the reported state
  function automatic res_t run_instr(cmd_t c);
    logic [31:0] a;
    logic [31:0] b;
    res_t        r;
    if (!model_running || model_pc >= model_prog_len) begin
      // stopped, or run off the end of the code: nothing moves
      model_running = 1'b0;
    end else begin
      model_pc += PC_STEP_OP;
      case (c.action)
        ACT_HALT: begin
          model_running = 1'b0;
        end
        ACT_CONST: begin
          model_pc += PC_STEP_IMM - PC_STEP_OP;
          stack_push(c.operand);
        end
        ACT_STRING: begin
          // address points just past the length word, then pc skips the text
          model_pc += PC_STEP_IMM - PC_STEP_OP;
          stack_push(model_code_base + model_pc);
          model_pc += c.operand;
        end
        ACT_ADD, ACT_SUB, ACT_MUL: begin
          b = stack_pop();
          a = stack_pop();
          if (c.action == ACT_ADD) stack_push(a + b);
          else if (c.action == ACT_SUB) stack_push(a - b);
          else stack_push(a * b);
        end
        ACT_LOAD: begin
          model_pc += PC_STEP_IMM - PC_STEP_OP;
          if (c.operand < LOCAL_COUNT) stack_push(model_locals[c.operand[LOC_AW-1:0]]);
        end
        ACT_STORE: begin
          model_pc += PC_STEP_IMM - PC_STEP_OP;
          if (c.operand < LOCAL_COUNT) model_locals[c.operand[LOC_AW-1:0]] = stack_pop();
        end
        ACT_CALL: begin
          void'(stack_pop());
          void'(stack_pop());
          stack_push(32'd0);
        end
        default: begin
          model_running = 1'b0;
        end
      endcase
    end
    r.top_value       = (model_depth > 0) ? model_stack[model_depth - 1] : 32'd0;
    r.stack_depth     = CNT_W'(model_depth);
    r.is_running      = model_running;
    r.program_counter = model_pc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle cycles before a transfer; runs of quiet items give back-to-back traffic
  function automatic int draw_gap(inout int left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(40, 1);
      quiet = ($urandom_range(3, 0) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(16, 0);
  endfunction

  function automatic void add_row(logic [7:0] act, logic [31:0] opnd, bit typed,
                                  logic [31:0] top = 0, int depth = 0,
                                  logic [31:0] pc = 0);
    dir_row_t row;
    row.instr.action         = act;
    row.instr.operand        = opnd;
    row.typed                = typed;
    row.want.top_value       = top;
    row.want.stack_depth     = CNT_W'(depth);
    row.want.is_running      = 1'b1;
    row.want.program_counter = pc;
    dir_rows.push_back(row);
  endfunction

  // mostly in range, with both ends and a share of out-of-range indexes
  function automatic logic [31:0] pick_local();
    case ($urandom_range(9, 0))
      0:       return 32'd0;
      1:       return LOCAL_COUNT - 1;
      2:       return LOCAL_COUNT;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom;
      default: return $urandom_range(LOCAL_COUNT - 1, 0);
    endcase
  endfunction

  // random instruction for a running machine; push_pct biases the stack depth
  function automatic cmd_t next_instr(int push_pct);
    cmd_t        c;
    logic [31:0] next_pc;
    c.operand = $urandom;
    if ($urandom_range(99, 0) < push_pct) begin
      case ($urandom_range(2, 0))
        0: begin
          c.action = ACT_CONST;
          case ($urandom_range(7, 0))
            0:       c.operand = 32'd0;
            1:       c.operand = 32'hFFFF_FFFF;
            2:       c.operand = $urandom_range(255, 0);
            3:       c.operand = 32'h8000_0000;
            default: c.operand = $urandom;
          endcase
        end
        1: begin
          c.action = ACT_STRING;
          if ($urandom_range(7, 0) != 0) c.operand = $urandom_range(300, 0);
          // keep clear of the program length, wrapping round is fine
          next_pc = model_pc + PC_STEP_IMM + c.operand;
          if (next_pc >= model_prog_len - PC_MARGIN) c.operand = $urandom_range(64, 0);
        end
        default: begin
          c.action  = ACT_LOAD;
          c.operand = pick_local();
        end
      endcase
    end else begin
      case ($urandom_range(4, 0))
        0: c.action = ACT_ADD;
        1: c.action = ACT_SUB;
        2: c.action = ACT_MUL;
        3: begin
          c.action  = ACT_STORE;
          c.operand = pick_local();
        end
        default: c.action = ACT_CALL;
      endcase
    end
    return c;
  endfunction

  int  send_left  = 0;
  bit  send_quiet = 1'b0;

  // one command transfer; the expectation is queued at the accepting edge
  task automatic send_instr(cmd_t c, bit typed = 1'b0, res_t want = '0);
    int   gap;
    res_t r;
    gap = draw_gap(send_left, send_quiet);
    repeat (gap) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!(cmd_valid && !cmd_stall));
    r = run_instr(c);
    pending_states.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // sender pause until every outstanding result has come back
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (pending_states.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_PROG_LEN) model_prog_len = data;
    else model_code_base = data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    int sink_left;
    bit sink_quiet;
    sink_left  = 0;
    sink_quiet = 1'b0;
    res_stall  = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = draw_gap(sink_left, sink_quiet);
      end
      repeat (gap) begin
        res_stall <= 1'b1;
        @(negedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
      @(negedge clk);
    end
  end

  // every result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_states.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result: top=%h depth=%0d run=%0b pc=%h",
                   res.top_value, res.stack_depth, res.is_running, res.program_counter);
        error_count++;
      end else begin
        if (res.top_value != pending_states[0].top_value ||
            res.stack_depth != pending_states[0].stack_depth ||
            res.is_running != pending_states[0].is_running ||
            res.program_counter != pending_states[0].program_counter) begin
          if (error_count < 10) begin
            $display("mismatch: exp top=%h depth=%0d run=%0b pc=%h",
                     pending_states[0].top_value, pending_states[0].stack_depth,
                     pending_states[0].is_running, pending_states[0].program_counter);
            $display("          got top=%h depth=%0d run=%0b pc=%h",
                     res.top_value, res.stack_depth, res.is_running, res.program_counter);
          end
          error_count++;
        end
        void'(pending_states.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cmd_t       c;
    int         at_full;
    stop_kind_t stop_kind;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cmd_valid = 1'b0;
    cmd       = '0;

    // model reset: empty stack, zeroed locals, running from pc 0
    foreach (model_stack[i]) model_stack[i] = 32'd0;
    foreach (model_locals[i]) model_locals[i] = 32'd0;
    model_depth     = 0;
    model_pc        = 32'd0;
    model_running   = 1'b1;
    model_prog_len  = 32'd0;
    model_code_base = 32'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // the program length resets to zero, which would stop the machine at once
    write_reg(CFG_PROG_LEN, 32'hFFFF_FFFF);
    write_reg(CFG_CODE_BASE, 32'd0);

    // directed table: empty-stack pops, wrap-around arithmetic, locals at
    // both ends and out of range, user call, string lengths that wrap pc
    add_row(ACT_ADD,    32'd0,         1, 32'd0,         1, 32'd1);
    add_row(ACT_SUB,    32'hFFFF_FFFF, 1, 32'd0,         1, 32'd2);
    add_row(ACT_CONST,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 2, 32'd7);
    add_row(ACT_CONST,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 3, 32'd12);
    add_row(ACT_ADD,    32'd0,         1, 32'hFFFF_FFFE, 2, 32'd13);
    add_row(ACT_MUL,    32'd0,         1, 32'd0,         1, 32'd14);
    add_row(ACT_CONST,  32'd0,         1, 32'd0,         2, 32'd19);
    add_row(ACT_CONST,  32'd1,         1, 32'd1,         3, 32'd24);
    add_row(ACT_SUB,    32'd0,         1, 32'hFFFF_FFFF, 2, 32'd25);
    add_row(ACT_STORE,  LOCAL_COUNT - 1, 1, 32'd0,       1, 32'd30);
    add_row(ACT_LOAD,   LOCAL_COUNT - 1, 1, 32'hFFFF_FFFF, 2, 32'd35);
    add_row(ACT_LOAD,   32'd0,         1, 32'd0,         3, 32'd40);
    add_row(ACT_STORE,  LOCAL_COUNT,   1, 32'd0,         3, 32'd45);
    add_row(ACT_LOAD,   32'hFFFF_FFFF, 1, 32'd0,         3, 32'd50);
    add_row(ACT_STORE,  32'd0,         1, 32'hFFFF_FFFF, 2, 32'd55);
    add_row(ACT_CALL,   32'd0,         1, 32'd0,         1, 32'd56);
    add_row(ACT_CALL,   32'hFFFF_FFFF, 1, 32'd0,         1, 32'd57);
    add_row(ACT_STRING, 32'd0,         1, 32'd62,        2, 32'd62);
    // huge length sends pc near the top, a short one then wraps it past zero
    add_row(ACT_STRING, 32'hFFFF_FF00, 0);
    add_row(ACT_CONST,  32'h5A5A_5A5A, 0);
    add_row(ACT_STRING, 32'h0000_00F0, 0);
    add_row(ACT_STRING, 32'hFFFF_FFE0, 0);
    add_row(ACT_MUL,    32'h1234_5678, 0);
    add_row(ACT_LOAD,   32'd5,         0);
    add_row(ACT_MUL,    32'd0,         0);
    foreach (dir_rows[i]) send_instr(dir_rows[i].instr, dir_rows[i].typed, dir_rows[i].want);

    // string addresses now wrap through the top of the address space
    wait_idle();
    write_reg(CFG_CODE_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_PROG_LEN, $urandom_range(32'hFFFF_FFFF, model_pc + 32'h0100_0000));

    // balanced mix; one long receiver hold-off fills the block up
    for (int i = 0; i < 40; i++) begin
      if (i == 20) hold_request = 1'b1;
      send_instr(next_instr(50));
    end

    // push-heavy stretch until the stack is full and pushes start dropping:
    // plain constants most of the way, the full mix near the top
    wait_idle();
    write_reg(CFG_CODE_BASE, $urandom);
    at_full = 0;
    while (at_full < 12) begin
      if (model_depth < STACK_DEPTH - 16) begin
        c.action  = ACT_CONST;
        c.operand = $urandom;
        send_instr(c);
      end else begin
        send_instr(next_instr(90));
      end
      if (model_depth == STACK_DEPTH) at_full++;
    end

    // pop-heavy stretch back down from full
    for (int i = 0; i < 30; i++) send_instr(next_instr(20));

    // only one way of stopping can be seen per run, the seed picks it
    wait_idle();
    stop_kind = stop_kind_t'($urandom_range(2, 0));
    c.operand = $urandom;
    case (stop_kind)
      END_BY_HALT: begin
        c.action = ACT_HALT;
      end
      END_BY_UNKNOWN: begin
        if ($urandom_range(1, 0) == 0) begin
          c.action = ACT_LIBC_FWD;
        end else begin
          do c.action = $urandom_range(255, 0);
          while (c.action inside {ACT_HALT, ACT_CONST, ACT_STRING, ACT_ADD, ACT_SUB,
                                  ACT_MUL, ACT_LOAD, ACT_STORE, ACT_CALL});
        end
      end
      default: begin
        // pc sits exactly on the end of the code
        write_reg(CFG_PROG_LEN, model_pc);
        c = next_instr(50);
      end
    endcase
    send_instr(c);

    // once stopped, any opcode just reports the frozen state
    for (int i = 0; i < 6; i++) begin
      c.action  = $urandom_range(255, 0);
      c.operand = $urandom;
      send_instr(c);
    end
    wait_idle();
    write_reg(CFG_PROG_LEN, 32'd0);
    write_reg(CFG_CODE_BASE, $urandom);
    for (int i = 0; i < 3; i++) begin
      c.action  = $urandom_range(255, 0);
      c.operand = $urandom;
      send_instr(c);
    end

    // drain, then leave room for any stray result
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
